/* src/mie_pkg.sv */
package mie_pkg;

	localparam logic [2:0] EXC_NONE        = 3'd0;
	localparam logic [2:0] EXC_RESERVED    = 3'd1;
	localparam logic [2:0] EXC_SYSCALL     = 3'd2;
	localparam logic [2:0] EXC_BREAK       = 3'd3;
	localparam logic [2:0] EXC_TRAP        = 3'd4;
	localparam logic [2:0] EXC_UNSUPPORTED = 3'd5;

	localparam logic CFG_START_PC   = 1'b0;
	localparam logic CFG_EXC_VECTOR = 1'b1;

	localparam logic [31:0] EXC_VECTOR_RESET = 32'h8000_0080;
	localparam logic [31:0] GPR_PTR_RESET    = 32'h8000_0000;
	localparam logic [4:0]  GPR_GP           = 5'd28;
	localparam logic [4:0]  GPR_SP           = 5'd29;
	localparam logic [4:0]  GPR_RA           = 5'd31;
	localparam logic [4:0]  GPR_ZERO         = 5'd0;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_REGIMM  = 6'h01;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_BLEZ    = 6'h06;
	localparam logic [5:0] OP_BGTZ    = 6'h07;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0A;
	localparam logic [5:0] OP_SLTIU   = 6'h0B;
	localparam logic [5:0] OP_ANDI    = 6'h0C;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_XORI    = 6'h0E;
	localparam logic [5:0] OP_LUI     = 6'h0F;
	localparam logic [5:0] OP_COP0    = 6'h10;
	localparam logic [5:0] OP_COP1    = 6'h11;
	localparam logic [5:0] OP_LB      = 6'h20;
	localparam logic [5:0] OP_LH      = 6'h21;
	localparam logic [5:0] OP_LWL     = 6'h22;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_LBU     = 6'h24;
	localparam logic [5:0] OP_LHU     = 6'h25;
	localparam logic [5:0] OP_LWR     = 6'h26;
	localparam logic [5:0] OP_SB      = 6'h28;
	localparam logic [5:0] OP_SH      = 6'h29;
	localparam logic [5:0] OP_SWL     = 6'h2A;
	localparam logic [5:0] OP_SW      = 6'h2B;
	localparam logic [5:0] OP_SWR     = 6'h2E;
	localparam logic [5:0] OP_LL      = 6'h30;
	localparam logic [5:0] OP_LWC1    = 6'h31;
	localparam logic [5:0] OP_SC      = 6'h38;
	localparam logic [5:0] OP_SWC1    = 6'h39;

	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_SRA     = 6'h03;
	localparam logic [5:0] FN_SLLV    = 6'h04;
	localparam logic [5:0] FN_SRLV    = 6'h06;
	localparam logic [5:0] FN_SRAV    = 6'h07;
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [5:0] FN_JALR    = 6'h09;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_BREAK   = 6'h0D;
	localparam logic [5:0] FN_SYNC    = 6'h0F;
	localparam logic [5:0] FN_MFHI    = 6'h10;
	localparam logic [5:0] FN_MTHI    = 6'h11;
	localparam logic [5:0] FN_MFLO    = 6'h12;
	localparam logic [5:0] FN_MTLO    = 6'h13;
	localparam logic [5:0] FN_MULT    = 6'h18;
	localparam logic [5:0] FN_MULTU   = 6'h19;
	localparam logic [5:0] FN_DIV     = 6'h1A;
	localparam logic [5:0] FN_DIVU    = 6'h1B;
	localparam logic [5:0] FN_ADD     = 6'h20;
	localparam logic [5:0] FN_ADDU    = 6'h21;
	localparam logic [5:0] FN_SUB     = 6'h22;
	localparam logic [5:0] FN_SUBU    = 6'h23;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_XOR     = 6'h26;
	localparam logic [5:0] FN_NOR     = 6'h27;
	localparam logic [5:0] FN_SLT     = 6'h2A;
	localparam logic [5:0] FN_SLTU    = 6'h2B;
	localparam logic [5:0] FN_TGE     = 6'h2C;
	localparam logic [5:0] FN_TGEU    = 6'h2D;
	localparam logic [5:0] FN_TLT     = 6'h2E;
	localparam logic [5:0] FN_TLTU    = 6'h2F;
	localparam logic [5:0] FN_TEQ     = 6'h30;
	localparam logic [5:0] FN_TNE     = 6'h32;

	localparam logic [4:0] RT_BLTZ   = 5'h00;
	localparam logic [4:0] RT_BGEZ   = 5'h01;
	localparam logic [4:0] RT_BLTZAL = 5'h10;
	localparam logic [4:0] RT_BGEZAL = 5'h11;

	typedef enum logic [1:0] {
		KIND_BASIC,
		KIND_MULT,
		KIND_DIV
	} kind_t;

	typedef struct packed {
		logic [31:0] word;
		kind_t       kind;
		logic        sgn;
		logic [2:0]  exc;
	} decoded_t;

	typedef struct packed {
		logic [31:0] npc;
		logic        wr;
		logic [4:0]  widx;
		logic [31:0] wval;
		logic [31:0] hi;
		logic [31:0] lo;
		logic [2:0]  exc;
	} result_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_READ,
		B_MUL,
		B_DIV,
		B_FIX,
		B_DONE
	} back_state_t;

	function automatic logic [31:0] gpr_reset_val(input logic [4:0] idx);
		logic [31:0] v;
		v = '0;
		if (idx == GPR_GP || idx == GPR_SP) v = GPR_PTR_RESET;
		return v;
	endfunction

endpackage

/* src/mie_channels.sv */
interface mie_instr_if;
	import mie_pkg::*;
	logic        valid;
	logic        ready;
	logic [31:0] instr_word;

	modport source (output valid, output instr_word, input ready);
	modport sink (input valid, input instr_word, output ready);
endinterface

interface mie_result_if;
	import mie_pkg::*;
	logic        valid;
	logic        ready;
	logic [31:0] pc_next;
	logic        reg_write;
	logic [4:0]  reg_index;
	logic [31:0] reg_value;
	logic [31:0] hi_value;
	logic [31:0] lo_value;
	logic [2:0]  exc_code;

	modport source (output valid, output pc_next, output reg_write, output reg_index,
		output reg_value, output hi_value, output lo_value, output exc_code, input ready);
	modport sink (input valid, input pc_next, input reg_write, input reg_index,
		input reg_value, input hi_value, input lo_value, input exc_code, output ready);
endinterface

/* src/mie_ram.sv */
module mie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

/* src/mie_front.sv */
module mie_front import mie_pkg::*; (
	mie_instr_if.sink instr_ch,
	input  logic      queue_full,
	output logic      push,
	output decoded_t  push_data
);

	logic [5:0] op;
	logic [5:0] fn;
	logic [4:0] rt;

	assign op = instr_ch.instr_word[31:26];
	assign fn = instr_ch.instr_word[5:0];
	assign rt = instr_ch.instr_word[20:16];

	assign instr_ch.ready = !queue_full;
	assign push = instr_ch.valid && !queue_full;

	always_comb begin
		push_data.word = instr_ch.instr_word;
		push_data.kind = KIND_BASIC;
		push_data.sgn  = 1'b0;
		push_data.exc  = EXC_NONE;
		case (op)
			OP_SPECIAL: begin
				case (fn)
					FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR,
					FN_SYNC, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_ADD, FN_ADDU,
					FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU,
					FN_TGE, FN_TGEU, FN_TLT, FN_TLTU, FN_TEQ, FN_TNE: ;
					FN_SYSCALL: push_data.exc = EXC_SYSCALL;
					FN_BREAK:   push_data.exc = EXC_BREAK;
					FN_MULT: begin
						push_data.kind = KIND_MULT;
						push_data.sgn  = 1'b1;
					end
					FN_MULTU: push_data.kind = KIND_MULT;
					FN_DIV: begin
						push_data.kind = KIND_DIV;
						push_data.sgn  = 1'b1;
					end
					FN_DIVU: push_data.kind = KIND_DIV;
					default: push_data.exc = EXC_RESERVED;
				endcase
			end
			OP_REGIMM: begin
				if (rt != RT_BLTZ && rt != RT_BGEZ && rt != RT_BLTZAL && rt != RT_BGEZAL)
					push_data.exc = EXC_RESERVED;
			end
			OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU,
			OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI: ;
			OP_COP0, OP_COP1, OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR,
			OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR, OP_LL, OP_LWC1, OP_SC, OP_SWC1:
				push_data.exc = EXC_UNSUPPORTED;
			default: push_data.exc = EXC_RESERVED;
		endcase
	end

endmodule

/* src/mie_queue.sv */
module mie_queue import mie_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  decoded_t push_data,
	output logic     full,
	input  logic     pop,
	output logic     empty,
	output decoded_t pop_data
);

	decoded_t   slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/mie_back.sv */
module mie_back import mie_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  decoded_t    q_data,
	output logic        q_pop,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	mie_result_if.source result_ch
);

	back_state_t state_q, state_n;
	decoded_t    item_q;
	logic [31:0] pc_q, hi_q, lo_q, vec_q;
	logic [31:0] gpr_vld_q;
	logic [31:0] a_q, b_q;
	logic [63:0] prod_q;
	logic [31:0] rem_q, quo_q, dvs_q;
	logic [4:0]  div_cnt_q;
	logic        qneg_q, rneg_q;
	result_t     res_q;
	logic        out_v_q;
	result_t     out_q;

	logic [31:0] ram_a, ram_b, a, b;
	logic [4:0]  rs, rt, rd, sa;
	logic [5:0]  op, fn;
	logic [31:0] imm, simm, seq, btgt;
	result_t     basic_res, fin_res;
	logic        fin, slot_free, out_load;
	result_t     out_n;
	logic [32:0] div_tmp;
	logic        div_ge;
	logic [31:0] mul_hi;

	assign op   = item_q.word[31:26];
	assign rs   = item_q.word[25:21];
	assign rt   = item_q.word[20:16];
	assign rd   = item_q.word[15:11];
	assign sa   = item_q.word[10:6];
	assign fn   = item_q.word[5:0];
	assign imm  = {16'h0000, item_q.word[15:0]};
	assign simm = {{16{item_q.word[15]}}, item_q.word[15:0]};
	assign seq  = pc_q + 32'd4;
	assign btgt = seq + {simm[29:0], 2'b00};

	mie_ram #(.WIDTH(32), .DEPTH(32)) u_ram_rs (
		.clk(clk), .we(fin && fin_res.wr), .waddr(fin_res.widx), .wdata(fin_res.wval),
		.raddr(q_data.word[25:21]), .rdata(ram_a)
	);

	mie_ram #(.WIDTH(32), .DEPTH(32)) u_ram_rt (
		.clk(clk), .we(fin && fin_res.wr), .waddr(fin_res.widx), .wdata(fin_res.wval),
		.raddr(q_data.word[20:16]), .rdata(ram_b)
	);

	// entries never written read as their reset value
	assign a = gpr_vld_q[rs] ? ram_a : gpr_reset_val(rs);
	assign b = gpr_vld_q[rt] ? ram_b : gpr_reset_val(rt);

	always_comb begin
		basic_res.npc  = seq;
		basic_res.wr   = 1'b0;
		basic_res.widx = '0;
		basic_res.wval = '0;
		basic_res.hi   = hi_q;
		basic_res.lo   = lo_q;
		basic_res.exc  = item_q.exc;
		if (item_q.exc == EXC_NONE) begin
			case (op)
				OP_SPECIAL: begin
					basic_res.widx = rd;
					case (fn)
						FN_SLL: begin basic_res.wr = 1'b1; basic_res.wval = b << sa; end
						FN_SRL: begin basic_res.wr = 1'b1; basic_res.wval = b >> sa; end
						FN_SRA: begin
							basic_res.wr = 1'b1;
							basic_res.wval = $signed(b) >>> sa;
						end
						FN_SLLV: begin basic_res.wr = 1'b1; basic_res.wval = b << a[4:0]; end
						FN_SRLV: begin basic_res.wr = 1'b1; basic_res.wval = b >> a[4:0]; end
						FN_SRAV: begin
							basic_res.wr = 1'b1;
							basic_res.wval = $signed(b) >>> a[4:0];
						end
						FN_JR: basic_res.npc = a;
						FN_JALR: begin
							basic_res.npc = a;
							basic_res.wr = 1'b1;
							basic_res.wval = seq;
						end
						FN_MFHI: begin basic_res.wr = 1'b1; basic_res.wval = hi_q; end
						FN_MTHI: basic_res.hi = a;
						FN_MFLO: begin basic_res.wr = 1'b1; basic_res.wval = lo_q; end
						FN_MTLO: basic_res.lo = a;
						FN_ADD, FN_ADDU: begin basic_res.wr = 1'b1; basic_res.wval = a + b; end
						FN_SUB, FN_SUBU: begin basic_res.wr = 1'b1; basic_res.wval = a - b; end
						FN_AND: begin basic_res.wr = 1'b1; basic_res.wval = a & b; end
						FN_OR:  begin basic_res.wr = 1'b1; basic_res.wval = a | b; end
						FN_XOR: begin basic_res.wr = 1'b1; basic_res.wval = a ^ b; end
						FN_NOR: begin basic_res.wr = 1'b1; basic_res.wval = ~(a | b); end
						FN_SLT: begin
							basic_res.wr = 1'b1;
							basic_res.wval = {31'd0, $signed(a) < $signed(b)};
						end
						FN_SLTU: begin basic_res.wr = 1'b1; basic_res.wval = {31'd0, a < b}; end
						FN_TGE:  if (!($signed(a) < $signed(b))) basic_res.exc = EXC_TRAP;
						FN_TGEU: if (a >= b) basic_res.exc = EXC_TRAP;
						FN_TLT:  if ($signed(a) < $signed(b)) basic_res.exc = EXC_TRAP;
						FN_TLTU: if (a < b) basic_res.exc = EXC_TRAP;
						FN_TEQ:  if (a == b) basic_res.exc = EXC_TRAP;
						FN_TNE:  if (a != b) basic_res.exc = EXC_TRAP;
						default: ;
					endcase
				end
				OP_REGIMM: begin
					// link is written whether or not the branch is taken
					if (rt[4]) begin
						basic_res.wr = 1'b1;
						basic_res.widx = GPR_RA;
						basic_res.wval = seq;
					end
					if (rt[0] != a[31]) basic_res.npc = btgt;
				end
				OP_J: basic_res.npc = {seq[31:28], item_q.word[25:0], 2'b00};
				OP_JAL: begin
					basic_res.npc = {seq[31:28], item_q.word[25:0], 2'b00};
					basic_res.wr = 1'b1;
					basic_res.widx = GPR_RA;
					basic_res.wval = seq;
				end
				OP_BEQ:  if (a == b) basic_res.npc = btgt;
				OP_BNE:  if (a != b) basic_res.npc = btgt;
				OP_BLEZ: if (a == 32'd0 || a[31]) basic_res.npc = btgt;
				OP_BGTZ: if (a != 32'd0 && !a[31]) basic_res.npc = btgt;
				OP_ADDI, OP_ADDIU: begin
					basic_res.wr = 1'b1; basic_res.widx = rt; basic_res.wval = a + simm;
				end
				OP_SLTI: begin
					basic_res.wr = 1'b1; basic_res.widx = rt;
					basic_res.wval = {31'd0, $signed(a) < $signed(simm)};
				end
				OP_SLTIU: begin
					basic_res.wr = 1'b1; basic_res.widx = rt;
					basic_res.wval = {31'd0, a < simm};
				end
				OP_ANDI: begin basic_res.wr = 1'b1; basic_res.widx = rt; basic_res.wval = a & imm; end
				OP_ORI:  begin basic_res.wr = 1'b1; basic_res.widx = rt; basic_res.wval = a | imm; end
				OP_XORI: begin basic_res.wr = 1'b1; basic_res.widx = rt; basic_res.wval = a ^ imm; end
				OP_LUI: begin
					basic_res.wr = 1'b1; basic_res.widx = rt;
					basic_res.wval = {item_q.word[15:0], 16'h0000};
				end
				default: ;
			endcase
		end
		if (basic_res.exc != EXC_NONE && basic_res.exc != EXC_UNSUPPORTED) begin
			basic_res.wr = 1'b0;
			basic_res.npc = vec_q;
		end
		if (basic_res.widx == GPR_ZERO) basic_res.wr = 1'b0;
		if (!basic_res.wr) begin
			basic_res.widx = '0;
			basic_res.wval = '0;
		end
	end

	assign mul_hi = prod_q[63:32] - ((item_q.sgn && a_q[31]) ? b_q : 32'd0)
		- ((item_q.sgn && b_q[31]) ? a_q : 32'd0);
	assign div_tmp = {rem_q, quo_q[31]};
	assign div_ge  = div_tmp >= {1'b0, dvs_q};

	assign slot_free = !out_v_q || result_ch.ready;

	always_comb begin
		state_n  = state_q;
		q_pop    = 1'b0;
		fin      = 1'b0;
		fin_res  = basic_res;
		out_load = 1'b0;
		out_n    = res_q;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					state_n = B_READ;
				end
			end
			B_READ: begin
				case (item_q.kind)
					KIND_MULT: state_n = B_MUL;
					KIND_DIV: begin
						if (b == 32'd0) begin
							fin = 1'b1;
							fin_res.hi = hi_q;
							fin_res.lo = lo_q;
						end else begin
							state_n = B_DIV;
						end
					end
					default: fin = 1'b1;
				endcase
			end
			B_MUL: begin
				fin = 1'b1;
				fin_res.hi = mul_hi;
				fin_res.lo = prod_q[31:0];
			end
			B_DIV: if (div_cnt_q == 5'd31) state_n = B_FIX;
			B_FIX: begin
				fin = 1'b1;
				fin_res.hi = rneg_q ? (32'd0 - rem_q) : rem_q;
				fin_res.lo = qneg_q ? (32'd0 - quo_q) : quo_q;
			end
			B_DONE: begin
				if (slot_free) begin
					out_load = 1'b1;
					state_n = B_IDLE;
				end
			end
			default: state_n = B_IDLE;
		endcase
		if (fin) begin
			if (slot_free) begin
				out_load = 1'b1;
				out_n = fin_res;
				state_n = B_IDLE;
			end else begin
				state_n = B_DONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			pc_q      <= '0;
			hi_q      <= '0;
			lo_q      <= '0;
			vec_q     <= EXC_VECTOR_RESET;
			gpr_vld_q <= '0;
			out_v_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				case (cfg_index)
					CFG_START_PC:   pc_q <= cfg_data;
					CFG_EXC_VECTOR: vec_q <= cfg_data;
					default: ;
				endcase
			end
			if (fin) begin
				pc_q <= fin_res.npc;
				hi_q <= fin_res.hi;
				lo_q <= fin_res.lo;
				if (fin_res.wr) gpr_vld_q[fin_res.widx] <= 1'b1;
			end
			if (out_load) out_v_q <= 1'b1;
			else if (result_ch.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) item_q <= q_data;
		if (fin) res_q <= fin_res;
		if (out_load) out_q <= out_n;
		if (state_q == B_READ) begin
			a_q    <= a;
			b_q    <= b;
			prod_q <= {32'd0, a} * {32'd0, b};
			// divide runs on magnitudes, signs applied at the end
			quo_q     <= (item_q.sgn && a[31]) ? (32'd0 - a) : a;
			dvs_q     <= (item_q.sgn && b[31]) ? (32'd0 - b) : b;
			rem_q     <= '0;
			div_cnt_q <= '0;
			qneg_q    <= item_q.sgn && (a[31] ^ b[31]);
			rneg_q    <= item_q.sgn && a[31];
		end else if (state_q == B_DIV) begin
			rem_q     <= div_ge ? 32'(div_tmp - {1'b0, dvs_q}) : div_tmp[31:0];
			quo_q     <= {quo_q[30:0], div_ge};
			div_cnt_q <= div_cnt_q + 5'd1;
		end
	end

	assign result_ch.valid     = out_v_q;
	assign result_ch.pc_next   = out_q.npc;
	assign result_ch.reg_write = out_q.wr;
	assign result_ch.reg_index = out_q.widx;
	assign result_ch.reg_value = out_q.wval;
	assign result_ch.hi_value  = out_q.hi;
	assign result_ch.lo_value  = out_q.lo;
	assign result_ch.exc_code  = out_q.exc;

endmodule

/* src/mips_integer_execute_core_top.sv */
// MIPS-I integer execute core.
// instr_ch takes one instruction word per transaction; result_ch returns one
// result per instruction, in order: next pc, the general register written (if
// any), HI, LO and an exception code.
// cfg_we/cfg_index/cfg_data write start_pc (index 0, also loads the pc at once)
// and exception_vector (index 1); write only while no instruction is in flight.
// A decoder classifies each word into a two-entry queue; the execute unit
// pops it, reads the register file (registered RAM read) and finishes. It
// handles one instruction at a time: ALU, branch and jump work finish in
// the read state, MULT/MULTU in a multiply state after it, DIV/DIVU in the
// shift-subtract divider (one quotient bit per cycle) and a sign-fix state,
// or in the read state when the divisor is zero. With the execute unit idle,
// the queue is popped in the cycle right after the accept.
// Reset clears the queue and output, sets pc to 0, HI/LO to 0, the vector to
// 0x80000080 and registers 28 and 29 to 0x80000000, others to 0.
// When result_ch stalls, the finished result is held; the queue keeps
// accepting until two decoded words are waiting.
module mips_integer_execute_core_top import mie_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	mie_instr_if.sink    instr_ch,
	mie_result_if.source result_ch,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);

	logic     q_full, q_empty, q_push, q_pop;
	decoded_t q_in, q_out;

	mie_front u_front (
		.instr_ch(instr_ch), .queue_full(q_full), .push(q_push), .push_data(q_in)
	);

	mie_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_data(q_in), .full(q_full),
		.pop(q_pop), .empty(q_empty), .pop_data(q_out)
	);

	mie_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_data(q_out), .q_pop(q_pop),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .result_ch(result_ch)
	);

endmodule

/* bench/mips_integer_execute_core_top_test.sv */
`timescale 1ns / 100ps

module mips_integer_execute_core_top_test;
	import mie_pkg::*;

	typedef struct {
		logic [31:0] word;
		bit          pinned;
		result_t     want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;

	mie_instr_if  instr_ch();
	mie_result_if result_ch();

	mips_integer_execute_core_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.instr_ch (instr_ch),
		.result_ch(result_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// architectural copy used for prediction
	logic [31:0] gpr [32];
	logic [31:0] hi_q, lo_q, pc_q, vec_q;

	result_t     pending_results[$];
	int          errors;
	int          n_sent;
	int          n_checked;
	int          exc_seen [8];
	int          idle_cycles;
	bit          hold_long;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] r_op(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
		logic [4:0] rd, logic [4:0] sa);
		return {OP_SPECIAL, rs, rt, rd, sa, fn};
	endfunction

	function automatic logic [31:0] i_op(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
		logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic result_t pin(logic [31:0] npc, logic wr, logic [4:0] widx,
		logic [31:0] wval, logic [31:0] hi, logic [31:0] lo, logic [2:0] exc);
		result_t r;
		r.npc = npc; r.wr = wr; r.widx = widx; r.wval = wval;
		r.hi = hi; r.lo = lo; r.exc = exc;
		return r;
	endfunction

	task automatic arch_reset();
		for (int i = 0; i < 32; i++) gpr[i] = '0;
		gpr[GPR_GP] = GPR_PTR_RESET;
		gpr[GPR_SP] = GPR_PTR_RESET;
		hi_q = '0;
		lo_q = '0;
		pc_q = '0;
		vec_q = EXC_VECTOR_RESET;
	endtask

	// execute one instruction against the architectural copy
	function automatic result_t execute_instr(logic [31:0] w);
		logic [5:0]  op, fn;
		logic [4:0]  rs, rt, rd, sa, widx;
		logic [31:0] imm, simm, a, b, seq, btgt, npc, wval, ma, mb, q, r;
		logic [63:0] p;
		logic        wr, take;
		logic [2:0]  exc;
		result_t     res;
		op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; sa = w[10:6];
		fn = w[5:0];
		imm = {16'h0, w[15:0]};
		simm = {{16{w[15]}}, w[15:0]};
		a = gpr[rs];
		b = gpr[rt];
		seq = pc_q + 32'd4;
		btgt = seq + (simm << 2);
		npc = seq;
		wr = 1'b0; widx = '0; wval = '0; exc = EXC_NONE;
		case (op)
			OP_SPECIAL: begin
				case (fn)
					FN_SLL: begin wr = 1; widx = rd; wval = b << sa; end
					FN_SRL: begin wr = 1; widx = rd; wval = b >> sa; end
					FN_SRA: begin wr = 1; widx = rd; wval = $signed(b) >>> sa; end
					FN_SLLV: begin wr = 1; widx = rd; wval = b << a[4:0]; end
					FN_SRLV: begin wr = 1; widx = rd; wval = b >> a[4:0]; end
					FN_SRAV: begin wr = 1; widx = rd; wval = $signed(b) >>> a[4:0]; end
					FN_JR: npc = a;
					FN_JALR: begin npc = a; wr = 1; widx = rd; wval = seq; end
					FN_SYSCALL: exc = EXC_SYSCALL;
					FN_BREAK: exc = EXC_BREAK;
					FN_SYNC: ;
					FN_MFHI: begin wr = 1; widx = rd; wval = hi_q; end
					FN_MTHI: hi_q = a;
					FN_MFLO: begin wr = 1; widx = rd; wval = lo_q; end
					FN_MTLO: lo_q = a;
					FN_MULT: begin
						p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
						hi_q = p[63:32]; lo_q = p[31:0];
					end
					FN_MULTU: begin
						p = {32'h0, a} * {32'h0, b};
						hi_q = p[63:32]; lo_q = p[31:0];
					end
					FN_DIV: if (b != 0) begin
						ma = a[31] ? -a : a;
						mb = b[31] ? -b : b;
						q = ma / mb; r = ma % mb;
						lo_q = (a[31] ^ b[31]) ? -q : q;
						hi_q = a[31] ? -r : r;
					end
					FN_DIVU: if (b != 0) begin lo_q = a / b; hi_q = a % b; end
					FN_ADD, FN_ADDU: begin wr = 1; widx = rd; wval = a + b; end
					FN_SUB, FN_SUBU: begin wr = 1; widx = rd; wval = a - b; end
					FN_AND: begin wr = 1; widx = rd; wval = a & b; end
					FN_OR: begin wr = 1; widx = rd; wval = a | b; end
					FN_XOR: begin wr = 1; widx = rd; wval = a ^ b; end
					FN_NOR: begin wr = 1; widx = rd; wval = ~(a | b); end
					FN_SLT: begin wr = 1; widx = rd; wval = {31'h0, $signed(a) < $signed(b)}; end
					FN_SLTU: begin wr = 1; widx = rd; wval = {31'h0, a < b}; end
					FN_TGE: if (!($signed(a) < $signed(b))) exc = EXC_TRAP;
					FN_TGEU: if (a >= b) exc = EXC_TRAP;
					FN_TLT: if ($signed(a) < $signed(b)) exc = EXC_TRAP;
					FN_TLTU: if (a < b) exc = EXC_TRAP;
					FN_TEQ: if (a == b) exc = EXC_TRAP;
					FN_TNE: if (a != b) exc = EXC_TRAP;
					default: exc = EXC_RESERVED;
				endcase
			end
			OP_REGIMM: begin
				if (rt == RT_BLTZ || rt == RT_BGEZ || rt == RT_BLTZAL || rt == RT_BGEZAL) begin
					take = rt[0] ? !a[31] : a[31];
					if (rt[4]) begin wr = 1; widx = GPR_RA; wval = seq; end
					if (take) npc = btgt;
				end else begin
					exc = EXC_RESERVED;
				end
			end
			OP_J, OP_JAL: begin
				npc = {seq[31:28], w[25:0], 2'b00};
				if (op == OP_JAL) begin wr = 1; widx = GPR_RA; wval = seq; end
			end
			OP_BEQ: if (a == b) npc = btgt;
			OP_BNE: if (a != b) npc = btgt;
			OP_BLEZ: if (a == 0 || a[31]) npc = btgt;
			OP_BGTZ: if (a != 0 && !a[31]) npc = btgt;
			OP_ADDI, OP_ADDIU: begin wr = 1; widx = rt; wval = a + simm; end
			OP_SLTI: begin wr = 1; widx = rt; wval = {31'h0, $signed(a) < $signed(simm)}; end
			OP_SLTIU: begin wr = 1; widx = rt; wval = {31'h0, a < simm}; end
			OP_ANDI: begin wr = 1; widx = rt; wval = a & imm; end
			OP_ORI: begin wr = 1; widx = rt; wval = a | imm; end
			OP_XORI: begin wr = 1; widx = rt; wval = a ^ imm; end
			OP_LUI: begin wr = 1; widx = rt; wval = {w[15:0], 16'h0}; end
			OP_COP0, OP_COP1, OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR,
			OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR, OP_LL, OP_LWC1, OP_SC, OP_SWC1:
				exc = EXC_UNSUPPORTED;
			default: exc = EXC_RESERVED;
		endcase
		if (exc inside {EXC_RESERVED, EXC_SYSCALL, EXC_BREAK, EXC_TRAP}) begin
			wr = 0;
			npc = vec_q;
		end
		if (wr && widx == GPR_ZERO) wr = 0;
		if (!wr) begin
			widx = '0;
			wval = '0;
		end else begin
			gpr[widx] = wval;
		end
		pc_q = npc;
		res.npc = npc; res.wr = wr; res.widx = widx; res.wval = wval;
		res.hi = hi_q; res.lo = lo_q; res.exc = exc;
		return res;
	endfunction

	function automatic logic [4:0] pick_reg();
		return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
	endfunction

	function automatic logic [31:0] random_instr();
		logic [5:0] alu_fns [29] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV,
			FN_JR, FN_JALR, FN_SYSCALL, FN_BREAK, FN_SYNC, FN_MFHI, FN_MTHI, FN_MFLO,
			FN_MTLO, FN_MULT, FN_MULTU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR,
			FN_XOR, FN_NOR, FN_SLT, FN_SLTU, FN_TGE, FN_TEQ};
		logic [5:0] imm_ops [8] = '{OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI,
			OP_XORI, OP_LUI};
		logic [5:0] br_ops [5] = '{OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_REGIMM};
		logic [4:0] br_rts [4] = '{RT_BLTZ, RT_BGEZ, RT_BLTZAL, RT_BGEZAL};
		logic [5:0] other_fns [6] = '{FN_TGEU, FN_TLT, FN_TLTU, FN_TNE, FN_DIV, FN_DIVU};
		logic [15:0] off;
		int k;
		k = $urandom_range(0, 99);
		off = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 16)) - 16'd8 : 16'($urandom);
		if (k < 6) return $urandom;
		if (k < 30)
			return i_op(imm_ops[$urandom_range(0, 7)], pick_reg(), pick_reg(), 16'($urandom));
		if (k < 62)
			return r_op(alu_fns[$urandom_range(0, 28)], pick_reg(), pick_reg(), pick_reg(),
				5'($urandom));
		if (k < 70)
			return r_op(other_fns[$urandom_range(0, 5)], pick_reg(), pick_reg(), pick_reg(),
				5'($urandom));
		if (k < 84) begin
			k = $urandom_range(0, 4);
			return i_op(br_ops[k], pick_reg(),
				(k == 4) ? br_rts[$urandom_range(0, 3)] : pick_reg(), off);
		end
		if (k < 89) return {($urandom_range(0, 1) ? OP_JAL : OP_J), 26'($urandom)};
		if (k < 95) return {6'($urandom_range(16, 63)), 26'($urandom)};
		return r_op(6'($urandom), pick_reg(), pick_reg(), pick_reg(), 5'($urandom));
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	task automatic write_reg(logic idx, logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_START_PC) begin
			pc_q = data;
		end else begin
			vec_q = data;
		end
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// hold valid until the transaction goes through
	task automatic send_instr(logic [31:0] w, bit pinned, result_t want, bit no_gap);
		int gap;
		result_t got;
		gap = no_gap ? 0 : $urandom_range(0, 12);
		if (gap > 0 && instr_ch.valid) begin
			instr_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end else if (gap > 0) begin
			repeat (gap) @(negedge clk);
		end
		instr_ch.valid <= 1'b1;
		instr_ch.instr_word <= w;
		do @(posedge clk); while (!(instr_ch.valid && instr_ch.ready));
		got = execute_instr(w);
		pending_results.push_back(pinned ? want : got);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic stop_sending();
		instr_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		stim_row_t rows [$];
		logic [31:0] starts [5];
		logic [31:0] vectors [5];
		bit burst;
		errors = 0; n_sent = 0; n_checked = 0; hold_long = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = CFG_START_PC; cfg_data = '0;
		instr_ch.valid = 1'b0;
		instr_ch.instr_word = '0;
		arch_reset();

		// values after reset are known, so the first rows carry their result
		rows.push_back('{i_op(OP_LUI, 0, 1, 16'hFFFF), 1,
			pin(32'h4, 1, 1, 32'hFFFF_0000, 0, 0, EXC_NONE)});
		rows.push_back('{r_op(FN_SYSCALL, 0, 0, 0, 0), 1,
			pin(EXC_VECTOR_RESET, 0, 0, 0, 0, 0, EXC_SYSCALL)});
		rows.push_back('{r_op(FN_BREAK, 0, 0, 0, 0), 1,
			pin(EXC_VECTOR_RESET, 0, 0, 0, 0, 0, EXC_BREAK)});
		rows.push_back('{32'hFC00_0000, 1, pin(EXC_VECTOR_RESET, 0, 0, 0, 0, 0, EXC_RESERVED)});
		rows.push_back('{i_op(OP_LW, 29, 2, 16'h0), 1,
			pin(EXC_VECTOR_RESET + 32'd4, 0, 0, 0, 0, 0, EXC_UNSUPPORTED)});
		rows.push_back('{i_op(OP_ORI, 0, 2, 16'hFFFF), 0, '0});
		rows.push_back('{i_op(OP_ADDIU, 0, 3, 16'h8000), 0, '0});
		rows.push_back('{i_op(OP_LUI, 0, 4, 16'h8000), 0, '0});
		rows.push_back('{i_op(OP_ADDI, 0, 5, 16'hFFFF), 0, '0});
		rows.push_back('{r_op(FN_ADD, 4, 4, 7, 0), 0, '0});
		rows.push_back('{r_op(FN_SUB, 0, 4, 8, 0), 0, '0});
		rows.push_back('{r_op(FN_SRA, 0, 4, 9, 31), 0, '0});
		rows.push_back('{r_op(FN_SLL, 0, 5, 11, 31), 0, '0});
		rows.push_back('{r_op(FN_SRAV, 5, 4, 12, 0), 0, '0});
		rows.push_back('{r_op(FN_MULT, 4, 5, 0, 0), 0, '0});
		rows.push_back('{r_op(FN_MULTU, 5, 5, 0, 0), 0, '0});
		rows.push_back('{r_op(FN_DIV, 4, 5, 0, 0), 0, '0});
		rows.push_back('{r_op(FN_DIV, 2, 0, 0, 0), 0, '0});
		rows.push_back('{r_op(FN_DIVU, 5, 2, 0, 0), 0, '0});
		rows.push_back('{r_op(FN_MFHI, 0, 0, 13, 0), 0, '0});
		rows.push_back('{r_op(FN_MFLO, 0, 0, 14, 0), 0, '0});
		rows.push_back('{r_op(FN_MTHI, 3, 0, 0, 0), 0, '0});
		rows.push_back('{i_op(OP_ORI, 0, 15, 16'h0100), 0, '0});
		rows.push_back('{r_op(FN_JALR, 15, 0, 15, 0), 0, '0});
		rows.push_back('{i_op(OP_REGIMM, 4, RT_BGEZAL, 16'h0010), 0, '0});
		rows.push_back('{i_op(OP_BEQ, 0, 0, 16'hFFFF), 0, '0});
		rows.push_back('{{OP_JAL, 26'h3FF_FFFF}, 0, '0});
		rows.push_back('{r_op(FN_TEQ, 0, 0, 0, 0), 0, '0});
		rows.push_back('{r_op(FN_SYNC, 0, 0, 0, 0), 0, '0});
		rows.push_back('{r_op(FN_ADDU, 5, 5, 0, 0), 0, '0});
		rows.push_back('{r_op(6'h01, 0, 0, 0, 0), 0, '0});
		rows.push_back('{i_op(OP_REGIMM, 0, 5'h02, 16'h0), 0, '0});

		starts = '{32'h0, 32'hFFFF_FFFC, 32'h0, 32'h0040_0000, 32'h0};
		vectors = '{EXC_VECTOR_RESET, 32'hFFFF_FFFF, 32'h0, 32'h8000_0180, 32'h0};
		starts[2] = $urandom;
		vectors[4] = $urandom;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) send_instr(rows[i].word, rows[i].pinned, rows[i].want, 0);

		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				stop_sending();
				drain();
				write_reg(CFG_START_PC, starts[ph]);
				write_reg(CFG_EXC_VECTOR, vectors[ph]);
			end
			for (int i = 0; i < 255; i++) begin
				burst = ((i / 40) % 3) == 1;
				if (ph == 2 && i == 100) hold_long = 1;
				if (ph == 3 && i == 130) begin
					stop_sending();
					while (pending_results.size() != 0) @(negedge clk);
				end
				send_instr(random_instr(), 0, '0, burst);
			end
		end
		stop_sending();
		while (pending_results.size() != 0) @(negedge clk);
		repeat (40) @(posedge clk);
		$display("ran %0d instructions in five pc/vector settings, %0d results checked", n_sent,
			n_checked);
		$display("exception codes seen: none %0d rsvd %0d sys %0d brk %0d trap %0d unsup %0d",
			exc_seen[0], exc_seen[1], exc_seen[2], exc_seen[3], exc_seen[4], exc_seen[5]);
		if (errors == 0) begin
			$display("mips_integer_execute_core_top_test OK");
		end else begin
			$display("mips_integer_execute_core_top_test NOT OK");
		end
		$finish;
	end

	// result side back-pressure
	initial begin
		int n;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
			if (hold_long) begin
				n = 400;
				hold_long = 0;
			end
			if (n > 0) begin
				result_ch.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				report("unexpected result pc_next", result_ch.pc_next, 32'd0);
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				exc_seen[want.exc]++;
				if (result_ch.pc_next !== want.npc) report("pc_next", result_ch.pc_next, want.npc);
				if (result_ch.reg_write !== want.wr)
					report("reg_write", 32'(result_ch.reg_write), 32'(want.wr));
				if (result_ch.reg_index !== want.widx)
					report("reg_index", 32'(result_ch.reg_index), 32'(want.widx));
				if (result_ch.reg_value !== want.wval)
					report("reg_value", result_ch.reg_value, want.wval);
				if (result_ch.hi_value !== want.hi) report("hi_value", result_ch.hi_value, want.hi);
				if (result_ch.lo_value !== want.lo) report("lo_value", result_ch.lo_value, want.lo);
				if (result_ch.exc_code !== want.exc)
					report("exc_code", 32'(result_ch.exc_code), 32'(want.exc));
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= 3000) begin
			$display("timeout: no transaction for %0d cycles", idle_cycles);
			$display("mips_integer_execute_core_top_test NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial idle_cycles = 0;

endmodule

/* filelist.f */
src/mie_pkg.sv
src/mie_channels.sv
src/mie_ram.sv
src/mie_front.sv
src/mie_queue.sv
src/mie_back.sv
src/mips_integer_execute_core_top.sv
bench/mips_integer_execute_core_top_test.sv
